>>> rtl/cgpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpt_pkg
// Shared types and status codes for the call-graph profile table.
// ----------------------------------------------------------------------------
package cgpt_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_STACK_FULL = 2'd2,
        ST_POP_EMPTY  = 2'd3
    } status_t;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic [31:0] func;
        logic [31:0] pfunc;
        logic [31:0] name;
        logic [31:0] pname;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [31:0] called;
        logic [31:0] returned;
    } entry_t;

endpackage

>>> rtl/cgpt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgpt_cell
// One table entry in the rotating ring; compares its key against the probe.
// ----------------------------------------------------------------------------
module cgpt_cell (
    input  logic            clk,
    input  logic            shift,
    input  cgpt_pkg::entry_t d,
    input  cgpt_pkg::key_t   probe,
    output cgpt_pkg::entry_t q,
    output logic            match
);
    import cgpt_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q     = entry_reg;
    assign match = (entry_reg.key == probe);

endmodule

>>> rtl/call_graph_profile_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_graph_profile_table
// A push or a valid pop scans the entry ring through one full rotation past
// its head compare before done; stack full or pop on an empty stack is
// answered from the idle state without a scan. A new item is not taken
// while busy. Results cannot be stalled.
// Reset clears stack level and entry count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module call_graph_profile_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] func_addr,
    input  logic [31:0] name_id,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  entry_index,
    output logic        is_new,
    output logic [31:0] called_count,
    output logic [31:0] returned_count
);
    import cgpt_pkg::*;

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = IDXW + 1;
    localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVLW = SAW + 1;

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t            state_reg;
    logic [CNTW-1:0]   count_reg;
    logic [CNTW-1:0]   k_reg;
    logic [LVLW-1:0]   level_reg;
    logic              found_reg;
    logic              fresh_reg;
    logic              action_reg;
    logic [31:0]       func_reg;
    logic [31:0]       name_reg;
    logic [IDXW-1:0]   hit_reg;
    logic              done_reg;
    status_t           status_reg;
    logic [7:0]        index_reg;
    logic              is_new_reg;
    logic [31:0]       called_reg;
    logic [31:0]       returned_reg;

    // Call stack memories
    logic [31:0]       stk_func [STACK_DEPTH];
    logic [31:0]       stk_name [STACK_DEPTH];
    logic [IDXW-1:0]   stk_entry [STACK_DEPTH];
    logic [31:0]       rd_func_reg;
    logic [31:0]       rd_name_reg;
    logic [IDXW-1:0]   rd_entry_reg;
    logic              stk_we;
    logic [IDXW-1:0]   stk_entry_in;
    logic [SAW-1:0]    wr_addr;
    logic [SAW-1:0]    top_addr;
    logic [LVLW-1:0]   level_dec;

    assign level_dec = level_reg - LVLW'(1);
    assign top_addr  = level_dec[SAW-1:0];
    assign wr_addr   = level_reg[SAW-1:0];

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_func[wr_addr]  <= func_reg;
            stk_name[wr_addr]  <= name_reg;
            stk_entry[wr_addr] <= stk_entry_in;
        end
        rd_func_reg  <= stk_func[top_addr];
        rd_name_reg  <= stk_name[top_addr];
        rd_entry_reg <= stk_entry[top_addr];
    end

    // Entry ring
    key_t   probe;
    entry_t ring_q [TABLE_DEPTH];
    logic   ring_m [TABLE_DEPTH];
    entry_t head_mod;
    logic   shift;

    assign probe.func  = func_reg;
    assign probe.name  = name_reg;
    assign probe.pfunc = (level_reg == '0) ? 32'd0 : rd_func_reg;
    assign probe.pname = (level_reg == '0) ? 32'd0 : rd_name_reg;
    assign shift       = (state_reg == S_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t d_in;
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign d_in = head_mod;
            end
            else
            begin : g_mid
                assign d_in = ring_q[gi+1];
            end
            cgpt_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (d_in),
                .probe (probe),
                .q     (ring_q[gi]),
                .match (ring_m[gi])
            );
        end
    endgenerate

    // Head update as the entry at index k_reg passes the compare
    logic   head_valid;
    logic   hit_now;
    logic   app_now;
    logic   ret_now;
    logic   last;

    assign head_valid = (k_reg < count_reg);
    assign hit_now = shift && (action_reg == ACT_PUSH) && !found_reg
                     && head_valid && ring_m[0];
    assign app_now = shift && (action_reg == ACT_PUSH) && !found_reg
                     && (k_reg == count_reg);
    assign ret_now = shift && (action_reg == ACT_POP)
                     && (k_reg[IDXW-1:0] == rd_entry_reg);
    assign last    = (k_reg == CNTW'(TABLE_DEPTH - 1));

    always_comb
    begin
        head_mod = ring_q[0];
        if (hit_now)
        begin
            head_mod.called = ring_q[0].called + 32'd1;
        end
        else if (app_now)
        begin
            head_mod.key      = probe;
            head_mod.called   = 32'd1;
            head_mod.returned = 32'd0;
        end
        else if (ret_now)
        begin
            head_mod.returned = ring_q[0].returned + 32'd1;
        end
    end

    logic [IDXW+7:0] k_wide;
    assign k_wide = (IDXW + 8)'(k_reg[IDXW-1:0]);

    // a match on the last entry is not yet in hit_reg
    assign stk_entry_in = (hit_now || app_now) ? k_reg[IDXW-1:0] : hit_reg;
    assign stk_we = shift && last && (action_reg == ACT_PUSH)
                    && (found_reg || hit_now || app_now);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            k_reg      <= '0;
            level_reg  <= '0;
            found_reg  <= 1'b0;
            fresh_reg  <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            index_reg  <= '0;
            is_new_reg <= 1'b0;
            called_reg <= '0;
            returned_reg <= '0;
            action_reg <= ACT_PUSH;
            func_reg   <= '0;
            name_reg   <= '0;
            hit_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg <= action;
                        func_reg   <= func_addr;
                        name_reg   <= name_id;
                        k_reg      <= '0;
                        found_reg  <= 1'b0;
                        fresh_reg  <= 1'b0;
                        index_reg  <= '0;
                        is_new_reg <= 1'b0;
                        called_reg <= '0;
                        returned_reg <= '0;
                        if (action == ACT_POP && level_reg == '0)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= ST_POP_EMPTY;
                        end
                        else if (action == ACT_PUSH
                                 && level_reg == LVLW'(STACK_DEPTH))
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= ST_STACK_FULL;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    k_reg <= k_reg + CNTW'(1);
                    if (hit_now || app_now || ret_now)
                    begin
                        found_reg    <= 1'b1;
                        hit_reg      <= k_reg[IDXW-1:0];
                        index_reg    <= k_wide[7:0];
                        called_reg   <= head_mod.called;
                        returned_reg <= head_mod.returned;
                    end
                    if (app_now)
                    begin
                        fresh_reg <= 1'b1;
                        count_reg <= count_reg + CNTW'(1);
                    end
                    if (last)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        if (action_reg == ACT_POP)
                        begin
                            status_reg <= ST_OK;
                            level_reg  <= level_dec;
                        end
                        else if (found_reg || hit_now || app_now)
                        begin
                            status_reg <= ST_OK;
                            is_new_reg <= fresh_reg || app_now;
                            level_reg  <= level_reg + LVLW'(1);
                        end
                        else
                        begin
                            // table full: drop captured values
                            status_reg   <= ST_TABLE_FULL;
                            index_reg    <= '0;
                            called_reg   <= '0;
                            returned_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign entry_index    = index_reg;
    assign is_new         = is_new_reg;
    assign called_count   = called_reg;
    assign returned_count = returned_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVLW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(TABLE_DEPTH))
        else $error("entry count beyond depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (!is_new && called_count == 32'd0
                                       && returned_count == 32'd0))
        else $error("rejected item carries data");

    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_new) |-> (called_count == 32'd1 && returned_count == 32'd0))
        else $error("new entry counts wrong");

endmodule
